@@ rtl/can_tseg_pkg.sv @@
package can_tseg_pkg;

  localparam int unsigned MEM_DEPTH = 4096;
  localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);
  localparam logic [11:0] MAX_MSG_BYTES = 12'd4095;

  // function codes on the request channel
  localparam logic [2:0] FN_RX_FRAME = 3'd0;
  localparam logic [2:0] FN_TICK     = 3'd1;
  localparam logic [2:0] FN_LOAD     = 3'd2;
  localparam logic [2:0] FN_START    = 3'd3;
  localparam logic [2:0] FN_READ     = 3'd4;

  // PCI frame types (upper nibble of byte 0)
  localparam logic [3:0] PCI_SF = 4'h0;
  localparam logic [3:0] PCI_FF = 4'h1;
  localparam logic [3:0] PCI_CF = 4'h2;
  localparam logic [3:0] PCI_FC = 4'h3;

  // flow status
  localparam logic [3:0] FS_CTS   = 4'h0;
  localparam logic [3:0] FS_WAIT  = 4'h1;
  localparam logic [3:0] FS_OVFLW = 4'h2;

  localparam logic [7:0] STMIN_MAX   = 8'h7F;
  localparam logic [7:0] STMIN_US_LO = 8'hF1;
  localparam logic [7:0] STMIN_US_HI = 8'hF9;

  // configuration register indexes
  localparam logic [2:0] CFG_ADV_BS   = 3'd0;
  localparam logic [2:0] CFG_ADV_ST   = 3'd1;
  localparam logic [2:0] CFG_CR_TO    = 3'd2;
  localparam logic [2:0] CFG_BS_TO    = 3'd3;
  localparam logic [2:0] CFG_WAIT_MAX = 3'd4;
  localparam logic [2:0] CFG_CAN_ID   = 3'd5;

  typedef enum logic [1:0] {
    PH_IDLE, PH_WAIT_FIRST_FC, PH_WAIT_FC, PH_SENDING
  } phase_t;

  typedef enum logic [2:0] {
    OP_FRAME, OP_TICK, OP_LOAD, OP_START, OP_READ, OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    CP_NONE, CP_TX_RD, CP_RX_WR, CP_RX_RD
  } copy_t;

  typedef enum logic [1:0] {
    ST_FETCH, ST_DECIDE, ST_COPY, ST_RESULT
  } eng_state_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] frame_bytes;
    logic [3:0]  frame_dlc;
    logic        functional_addressing;
    logic [11:0] byte_index;
    logic [7:0]  byte_value;
    logic [11:0] send_length;
  } req_item_t;

  typedef struct packed {
    logic        frame_out_valid;
    logic [63:0] frame_out_bytes;
    logic [28:0] frame_out_id;
    logic        message_done;
    logic [11:0] message_length;
    logic        message_functional;
    logic [7:0]  read_data;
    logic        send_busy;
  } rsp_item_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] frame_bytes;
    logic [3:0]  dlc;
    logic        functional;
    logic [11:0] byte_index;
    logic [7:0]  byte_value;
    logic [11:0] send_length;
  } q_item_t;

  typedef struct packed {
    logic [7:0]  adv_bs;
    logic [7:0]  adv_st;
    logic [15:0] cr_to;
    logic [15:0] bs_to;
    logic [7:0]  wait_max;
    logic [28:0] can_id;
  } cfg_t;

  function automatic logic [7:0] stmin_clamp(input logic [7:0] st);
    logic [7:0] r;
    if (st >= STMIN_US_LO && st <= STMIN_US_HI) r = 8'd1;
    else if (st > STMIN_MAX) r = STMIN_MAX;
    else r = st;
    return r;
  endfunction

endpackage

@@ rtl/can_tseg_ram.sv @@
module can_tseg_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/can_tseg_front.sv @@
module can_tseg_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  can_tseg_pkg::req_item_t  req,
  output logic                     q_valid,
  output can_tseg_pkg::q_item_t    q_item,
  input  logic                     pop
);
  import can_tseg_pkg::*;

  q_item_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  q_item_t    cls;
  logic       push;

  always_comb begin
    cls.frame_bytes = req.frame_bytes;
    cls.dlc         = (req.frame_dlc > 4'd8) ? 4'd8 : req.frame_dlc;
    cls.functional  = req.functional_addressing;
    cls.byte_index  = req.byte_index;
    cls.byte_value  = req.byte_value;
    cls.send_length = req.send_length;
    unique case (req.func)
      FN_RX_FRAME: cls.op = OP_FRAME;
      FN_TICK:     cls.op = OP_TICK;
      FN_LOAD:     cls.op = OP_LOAD;
      FN_START:    cls.op = OP_START;
      FN_READ:     cls.op = OP_READ;
      default:     cls.op = OP_NOP;
    endcase
  end

  assign req_ready = (count != 2'd2);
  assign push      = req_valid && req_ready;
  assign q_valid   = (count != 2'd0);
  assign q_item    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/can_tseg_engine.sv @@
module can_tseg_engine (
  input  logic                    clk,
  input  logic                    rst,
  input  can_tseg_pkg::cfg_t      cfg,
  input  logic                    q_valid,
  input  can_tseg_pkg::q_item_t   q_item,
  output logic                    pop,
  output logic                    rsp_valid,
  input  logic                    rsp_ready,
  output can_tseg_pkg::rsp_item_t rsp
);
  import can_tseg_pkg::*;

  eng_state_t state, state_next;

  // protocol state
  phase_t      phase, phase_next;
  logic        rx_wait, rx_wait_next;
  logic [11:0] send_total, send_total_next;
  logic [11:0] send_pos, send_pos_next;
  logic [3:0]  send_seq, send_seq_next;
  logic [7:0]  send_blk, send_blk_next;
  logic [7:0]  wait_seen, wait_seen_next;
  logic [7:0]  peer_bs, peer_bs_next;
  logic [7:0]  peer_st, peer_st_next;
  logic [15:0] send_timer, send_timer_next;
  logic [11:0] rx_total, rx_total_next;
  logic [11:0] rx_pos, rx_pos_next;
  logic [3:0]  rx_seq, rx_seq_next;
  logic [7:0]  rx_blk, rx_blk_next;
  logic [15:0] rx_timer, rx_timer_next;
  logic        last_func, last_func_next;

  // current item, copy job, pending result
  q_item_t     itm;
  logic [7:0]  d [8];
  copy_t       job_dir, job_dir_next;
  logic [2:0]  job_cnt, job_cnt_next;
  logic [11:0] job_addr, job_addr_next;
  logic [2:0]  job_off, job_off_next;
  logic [2:0]  iss;
  logic [2:0]  rcv;
  logic        rd_pend;
  rsp_item_t   res, res_next;
  logic        tx_we;

  // decode temporaries
  logic [3:0]  ptype, pnib;
  logic        ok;
  logic [7:0]  st_eff;
  logic [11:0] flen;
  logic [3:0]  avail;
  logic [11:0] left;
  logic [2:0]  ncopy;
  logic [11:0] newpos;
  logic [7:0]  blk_inc;
  logic        fire;
  logic        flow_req;
  logic [3:0]  flow_st;
  logic        fvalid, done;
  logic [63:0] frm;

  // copy control
  logic        issue, cap, copy_end, rsp_load;
  logic [2:0]  wr_idx, cap_idx;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]  tx_rdata, rx_rdata, cap_data;

  always_comb begin
    for (int k = 0; k < 8; k++) d[k] = itm.frame_bytes[8*k +: 8];
  end

  always_comb begin
    phase_next = phase; rx_wait_next = rx_wait; send_total_next = send_total;
    send_pos_next = send_pos; send_seq_next = send_seq; send_blk_next = send_blk;
    wait_seen_next = wait_seen; peer_bs_next = peer_bs; peer_st_next = peer_st;
    send_timer_next = send_timer; rx_total_next = rx_total; rx_pos_next = rx_pos;
    rx_seq_next = rx_seq; rx_blk_next = rx_blk; rx_timer_next = rx_timer;
    last_func_next = last_func;
    job_dir_next = CP_NONE; job_cnt_next = 3'd0; job_addr_next = 12'd0; job_off_next = 3'd0;
    ptype = d[0][7:4]; pnib = d[0][3:0];
    ok = 1'b0; st_eff = peer_st; flen = {pnib, d[1]};
    avail = 4'd0; left = 12'd0; ncopy = 3'd0; newpos = 12'd0; blk_inc = 8'd0;
    fire = 1'b0; flow_req = 1'b0; flow_st = FS_CTS;
    fvalid = 1'b0; done = 1'b0; frm = 64'd0; tx_we = 1'b0;

    unique case (itm.op)
      OP_FRAME: begin
        ok = (ptype == PCI_FC) ? !rx_wait : (phase == PH_IDLE);
        if (ok && !(itm.functional && ptype != PCI_SF)) begin
          last_func_next = itm.functional;
          if (ptype == PCI_FC) begin
            if (phase == PH_WAIT_FC || phase == PH_WAIT_FIRST_FC) begin
              send_timer_next = 16'd0;
              if (itm.dlc < 4'd3) begin
                phase_next = PH_IDLE;
              end else begin
                if (phase == PH_WAIT_FIRST_FC) begin
                  peer_bs_next = d[1];
                  st_eff = stmin_clamp(d[2]);
                  peer_st_next = st_eff;
                end
                if (pnib == FS_CTS) begin
                  send_blk_next = 8'd0;
                  wait_seen_next = 8'd0;
                  phase_next = PH_SENDING;
                  send_timer_next = {8'd0, st_eff};
                end else if (pnib == FS_WAIT) begin
                  if (wait_seen >= cfg.wait_max) begin
                    phase_next = PH_IDLE;
                  end else begin
                    phase_next = PH_WAIT_FC;
                    send_timer_next = cfg.bs_to;
                  end
                  if (wait_seen != 8'hFF) wait_seen_next = wait_seen + 8'd1;
                end else begin
                  phase_next = PH_IDLE;
                end
              end
            end
          end else if (ptype == PCI_SF) begin
            rx_timer_next = 16'd0;
            rx_wait_next = 1'b0;
            rx_total_next = {8'd0, pnib};
            if (itm.dlc >= 4'd1 && pnib != 4'd0 && pnib <= itm.dlc - 4'd1) begin
              rx_pos_next = {8'd0, pnib};
              job_dir_next = CP_RX_WR;
              job_cnt_next = pnib[2:0];
              job_off_next = 3'd1;
              done = 1'b1;
            end
          end else if (ptype == PCI_FF) begin
            rx_timer_next = 16'd0;
            rx_wait_next = 1'b0;
            rx_total_next = flen;
            if (flen >= 12'd8) begin
              if (flen <= MAX_MSG_BYTES) begin
                avail = (itm.dlc > 4'd2) ? itm.dlc - 4'd2 : 4'd0;
                rx_pos_next = {8'd0, avail};
                job_dir_next = CP_RX_WR;
                job_cnt_next = avail[2:0];
                job_off_next = 3'd2;
                rx_seq_next = 4'd1;
                rx_wait_next = 1'b1;
                flow_req = 1'b1;
              end else begin
                flow_req = 1'b1;
                flow_st = FS_OVFLW;
              end
            end
          end else if (ptype == PCI_CF) begin
            if (rx_wait) begin
              rx_timer_next = 16'd0;
              if (pnib != rx_seq) begin
                rx_wait_next = 1'b0;
              end else begin
                rx_seq_next = rx_seq + 4'd1;
                avail = (itm.dlc >= 4'd1) ? itm.dlc - 4'd1 : 4'd0;
                left = rx_total - rx_pos;
                ncopy = (left < {8'd0, avail}) ? left[2:0] : avail[2:0];
                job_dir_next = CP_RX_WR;
                job_cnt_next = ncopy;
                job_addr_next = rx_pos;
                job_off_next = 3'd1;
                newpos = rx_pos + {9'd0, ncopy};
                rx_pos_next = newpos;
                if (newpos < rx_total) begin
                  blk_inc = rx_blk + 8'd1;
                  rx_blk_next = blk_inc;
                  if (cfg.adv_bs == 8'd0 || blk_inc < cfg.adv_bs) begin
                    rx_timer_next = cfg.cr_to;
                  end else begin
                    flow_req = 1'b1;
                  end
                end else begin
                  done = 1'b1;
                  rx_wait_next = 1'b0;
                end
              end
            end
          end
        end
      end
      OP_TICK: begin
        if (phase == PH_WAIT_FC || phase == PH_WAIT_FIRST_FC) begin
          if (send_timer != 16'd0) begin
            send_timer_next = send_timer - 16'd1;
            if (send_timer == 16'd1) phase_next = PH_IDLE;
          end
        end else if (phase == PH_SENDING) begin
          if (peer_st != 8'd0) begin
            if (send_timer != 16'd0) begin
              send_timer_next = send_timer - 16'd1;
              fire = (send_timer == 16'd1);
            end
          end else begin
            fire = 1'b1;
          end
        end
        if (fire) begin
          fvalid = 1'b1;
          frm[7:0] = {PCI_CF, send_seq};
          send_seq_next = send_seq + 4'd1;
          blk_inc = send_blk + 8'd1;
          send_blk_next = blk_inc;
          left = send_total - send_pos;
          ncopy = (left < 12'd7) ? left[2:0] : 3'd7;
          job_dir_next = CP_TX_RD;
          job_cnt_next = ncopy;
          job_addr_next = send_pos;
          job_off_next = 3'd1;
          newpos = send_pos + {9'd0, ncopy};
          send_pos_next = newpos;
          if (newpos < send_total) begin
            if (peer_bs != 8'd0 && blk_inc >= peer_bs) begin
              phase_next = PH_WAIT_FC;
              send_timer_next = cfg.bs_to;
            end else begin
              send_timer_next = {8'd0, peer_st};
            end
          end else begin
            phase_next = PH_IDLE;
          end
        end
        if (rx_wait && rx_timer != 16'd0) begin
          rx_timer_next = rx_timer - 16'd1;
          if (rx_timer == 16'd1) rx_wait_next = 1'b0;
        end
      end
      OP_LOAD: begin
        tx_we = (phase == PH_IDLE);
      end
      OP_START: begin
        if (phase == PH_IDLE && itm.send_length <= MAX_MSG_BYTES) begin
          send_total_next = itm.send_length;
          wait_seen_next = 8'd0;
          fvalid = 1'b1;
          job_dir_next = CP_TX_RD;
          if (itm.send_length < 12'd8) begin
            frm[7:0] = itm.send_length[7:0];
            job_cnt_next = itm.send_length[2:0];
            job_off_next = 3'd1;
            send_pos_next = itm.send_length;
          end else begin
            frm[7:0] = {PCI_FF, itm.send_length[11:8]};
            frm[15:8] = itm.send_length[7:0];
            job_cnt_next = 3'd6;
            job_off_next = 3'd2;
            send_pos_next = 12'd6;
            send_seq_next = 4'd1;
            phase_next = PH_WAIT_FIRST_FC;
            send_timer_next = cfg.bs_to;
          end
        end
      end
      OP_READ: begin
        job_dir_next = CP_RX_RD;
        job_cnt_next = 3'd1;
        job_addr_next = itm.byte_index;
      end
      default: ;
    endcase

    if (flow_req) begin
      fvalid = 1'b1;
      frm[7:0] = {PCI_FC, flow_st};
      frm[15:8] = cfg.adv_bs;
      frm[23:16] = cfg.adv_st;
      rx_blk_next = 8'd0;
      rx_timer_next = cfg.cr_to;
    end

    res_next.frame_out_valid    = fvalid;
    res_next.frame_out_bytes    = frm;
    res_next.frame_out_id       = fvalid ? cfg.can_id : 29'd0;
    res_next.message_done       = done;
    res_next.message_length     = done ? rx_total_next : 12'd0;
    res_next.message_functional = done && last_func_next;
    res_next.read_data          = 8'd0;
    res_next.send_busy          = (phase_next != PH_IDLE);
  end

  // copy loop: one buffer byte per cycle, reads land in the cycle after they are issued
  assign issue    = (state == ST_COPY) && (iss != job_cnt);
  assign cap      = (state == ST_COPY) && rd_pend;
  assign wr_idx   = job_off + iss;
  assign cap_idx  = job_off + rcv;
  assign rd_addr  = job_addr + {9'd0, iss};
  assign cap_data = (job_dir == CP_RX_RD) ? rx_rdata : tx_rdata;
  assign copy_end = (job_dir == CP_RX_WR) ? (iss == job_cnt) : (rcv == job_cnt);
  assign rsp_load = (state == ST_RESULT) && (!rsp_valid || rsp_ready);
  assign pop      = (state == ST_FETCH) && q_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_FETCH:  if (q_valid) state_next = ST_DECIDE;
      ST_DECIDE: state_next = (job_cnt_next == 3'd0) ? ST_RESULT : ST_COPY;
      ST_COPY:   if (copy_end) state_next = ST_RESULT;
      ST_RESULT: if (rsp_load) state_next = ST_FETCH;
      default:   state_next = ST_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FETCH;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; rx_wait <= 1'b0; send_total <= 12'd0; send_pos <= 12'd0;
      send_seq <= 4'd0; send_blk <= 8'd0; wait_seen <= 8'd0; peer_bs <= 8'd0;
      peer_st <= 8'd0; send_timer <= 16'd0; rx_total <= 12'd0; rx_pos <= 12'd0;
      rx_seq <= 4'd0; rx_blk <= 8'd0; rx_timer <= 16'd0; last_func <= 1'b0;
      iss <= 3'd0; rcv <= 3'd0; rd_pend <= 1'b0; rsp_valid <= 1'b0;
    end else begin
      if (state == ST_DECIDE) begin
        phase <= phase_next; rx_wait <= rx_wait_next; send_total <= send_total_next;
        send_pos <= send_pos_next; send_seq <= send_seq_next; send_blk <= send_blk_next;
        wait_seen <= wait_seen_next; peer_bs <= peer_bs_next; peer_st <= peer_st_next;
        send_timer <= send_timer_next; rx_total <= rx_total_next; rx_pos <= rx_pos_next;
        rx_seq <= rx_seq_next; rx_blk <= rx_blk_next; rx_timer <= rx_timer_next;
        last_func <= last_func_next;
        iss <= 3'd0;
        rcv <= 3'd0;
      end
      if (issue) iss <= iss + 3'd1;
      if (cap) rcv <= rcv + 3'd1;
      rd_pend <= issue && (job_dir != CP_RX_WR);
      if (rsp_load) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) itm <= q_item;
    if (state == ST_DECIDE) begin
      job_dir  <= job_dir_next;
      job_cnt  <= job_cnt_next;
      job_addr <= job_addr_next;
      job_off  <= job_off_next;
      res      <= res_next;
    end
    if (cap) begin
      if (job_dir == CP_RX_RD) res.read_data <= cap_data;
      else res.frame_out_bytes[{cap_idx, 3'b000} +: 8] <= cap_data;
    end
    if (rsp_load) rsp <= res;
  end

  can_tseg_ram #(.Width(8), .Depth(MEM_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we && (state == ST_DECIDE)),
    .waddr (itm.byte_index),
    .wdata (itm.byte_value),
    .raddr (rd_addr),
    .rdata (tx_rdata)
  );

  can_tseg_ram #(.Width(8), .Depth(MEM_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (issue && (job_dir == CP_RX_WR)),
    .waddr (rd_addr),
    .wdata (d[wr_idx]),
    .raddr (rd_addr),
    .rdata (rx_rdata)
  );

endmodule

@@ rtl/can_transport_segmenter_unit.sv @@
// The engine finishes one item, including its result, before it takes the next; its pace
// is set by the byte-wide tx/rx buffer RAMs moving one byte per cycle. A two-entry input
// queue and the result register let both channels stall independently. Reset (rst,
// synchronous) clears the send/receive state and loads register defaults; buffer
// contents are kept.
module can_transport_segmenter_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  can_tseg_pkg::req_item_t req,
  output logic                    rsp_valid,
  input  logic                    rsp_ready,
  output can_tseg_pkg::rsp_item_t rsp,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [4:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import can_tseg_pkg::*;

  cfg_t    cfg;
  q_item_t q_item;
  logic    q_valid;
  logic    pop;
  logic    cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adv_bs   <= 8'd0;
      cfg.adv_st   <= 8'd0;
      cfg.cr_to    <= 16'd1000;
      cfg.bs_to    <= 16'd1000;
      cfg.wait_max <= 8'd0;
      cfg.can_id   <= 29'd0;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        CFG_ADV_BS:   cfg.adv_bs   <= pwdata[7:0];
        CFG_ADV_ST:   cfg.adv_st   <= pwdata[7:0];
        CFG_CR_TO:    cfg.cr_to    <= pwdata[15:0];
        CFG_BS_TO:    cfg.bs_to    <= pwdata[15:0];
        CFG_WAIT_MAX: cfg.wait_max <= pwdata[7:0];
        CFG_CAN_ID:   cfg.can_id   <= pwdata[28:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      CFG_ADV_BS:   prdata = {24'd0, cfg.adv_bs};
      CFG_ADV_ST:   prdata = {24'd0, cfg.adv_st};
      CFG_CR_TO:    prdata = {16'd0, cfg.cr_to};
      CFG_BS_TO:    prdata = {16'd0, cfg.bs_to};
      CFG_WAIT_MAX: prdata = {24'd0, cfg.wait_max};
      CFG_CAN_ID:   prdata = {3'd0, cfg.can_id};
      default:      prdata = 32'd0;
    endcase
  end

  can_tseg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  can_tseg_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  a_idle_frame_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.frame_out_valid |->
      rsp.frame_out_bytes == 64'd0 && rsp.frame_out_id == 29'd0)
    else $error("frame fields set without a frame");

  a_idle_msg_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.message_done |->
      rsp.message_length == 12'd0 && !rsp.message_functional)
    else $error("message fields set without done");

  a_frame_xor_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.frame_out_valid && rsp.message_done))
    else $error("frame emitted together with message done");

endmodule
